// ----- hw/rtl/sha1s_pkg.sv -----
// ============================================================================
// SHA-1 stream hasher package
// Shared types and constants for the SHA-1 stream hasher and its sub-blocks.
// ============================================================================
package sha1s_pkg;

    typedef enum logic [1:0]
    {
        FUNC_ABSORB     = 2'd0,
        FUNC_ABSORB_FIN = 2'd1,
        FUNC_FINISH     = 2'd2,
        FUNC_UNUSED     = 2'd3
    } func_t;

    localparam logic [31:0] SHA1_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] ROUND_K0 = 32'h5A827999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_GROUP1 = 7'd20;
    localparam logic [6:0] ROUND_GROUP2 = 7'd40;
    localparam logic [6:0] ROUND_GROUP3 = 7'd60;
    localparam logic [6:0] ROUND_LAST   = 7'd79;

    localparam logic [5:0] POS_LENGTH = 6'd56;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    typedef struct packed
    {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       round_en;
        logic [6:0] round_idx;
        logic       add_en;
        logic       init_en;
        logic [2:0] word_idx;
    } ctl_t;

endpackage

// ----- hw/rtl/sha1s_datapath.sv -----
// ============================================================================
// SHA-1 datapath
// Block window, working variables, chaining value and the shared round unit.
// ============================================================================
module sha1s_datapath
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output logic [31:0] digest_word
);

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  chain_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  ca, cb, cc, cd, ce;
    logic [31:0]  w0, w2, w8, w13, mix_w, new_w;
    logic [31:0]  f_val, k_val, tmp;
    logic         first;

    assign first = (ctl.round_idx == 7'd0);
    assign ca    = first ? chain_reg[0] : a_reg;
    assign cb    = first ? chain_reg[1] : b_reg;
    assign cc    = first ? chain_reg[2] : c_reg;
    assign cd    = first ? chain_reg[3] : d_reg;
    assign ce    = first ? chain_reg[4] : e_reg;

    // The window holds the sixteen schedule words of the current round, oldest at the top.
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign mix_w = w13 ^ w8 ^ w2 ^ w0;
    assign new_w = {mix_w[30:0], mix_w[31]};

    always_comb
    begin
        priority if (ctl.round_idx < ROUND_GROUP1)
        begin
            f_val = (cb & cc) | (~cb & cd);
            k_val = ROUND_K0;
        end
        else if (ctl.round_idx < ROUND_GROUP2)
        begin
            f_val = cb ^ cc ^ cd;
            k_val = ROUND_K1;
        end
        else if (ctl.round_idx < ROUND_GROUP3)
        begin
            f_val = (cb & cc) | (cb & cd) | (cc & cd);
            k_val = ROUND_K2;
        end
        else
        begin
            f_val = cb ^ cc ^ cd;
            k_val = ROUND_K3;
        end
    end

    assign tmp = {ca[26:0], ca[31:27]} + f_val + ce + k_val + w0;

    always_comb
    begin
        blk_next = blk_reg;
        if (ctl.shift_en)
        begin
            blk_next = {blk_reg[503:0], ctl.shift_byte};
        end
        else if (ctl.round_en)
        begin
            blk_next = {blk_reg[479:0], new_w};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (ctl.round_en)
        begin
            a_reg <= tmp;
            b_reg <= ca;
            c_reg <= {cb[1:0], cb[31:2]};
            d_reg <= cc;
            e_reg <= cd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= SHA1_IV[i];
            end
        end
        else if (ctl.init_en)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= SHA1_IV[i];
            end
        end
        else if (ctl.add_en)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    always_comb
    begin
        unique case (ctl.word_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

// ----- hw/rtl/sha1s_ctrl.sv -----
// ============================================================================
// SHA-1 sequencer
// Byte intake, bit count, padding generation, round sequencing and digest output.
// ============================================================================
module sha1s_ctrl
    import sha1s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output ctl_t       ctl
);

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [60:0]       cnt_reg, cnt_next;
    logic [7:0][7:0]   len_reg, len_next;
    logic [6:0]        rnd_reg, rnd_next;
    logic [2:0]        widx_reg, widx_next;
    logic              fin_reg, fin_next;
    logic              sent_reg, sent_next;
    logic              lenph_reg, lenph_next;
    logic              done_reg, done_next;
    logic [5:0]        pos;
    func_t             fcode;

    assign pos       = cnt_reg[5:0];
    assign fcode     = func_t'(func);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        fin_next   = fin_reg;
        sent_next  = sent_reg;
        lenph_next = lenph_reg;
        done_next  = done_reg;
        ctl        = '0;
        ctl.round_idx = rnd_reg;
        ctl.word_idx  = widx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (fcode != FUNC_UNUSED))
                begin
                    if (fcode != FUNC_FINISH)
                    begin
                        ctl.shift_en   = 1'b1;
                        ctl.shift_byte = data_byte;
                        cnt_next       = cnt_reg + 61'd1;
                    end
                    if (fcode != FUNC_ABSORB)
                    begin
                        fin_next   = 1'b1;
                        sent_next  = 1'b0;
                        lenph_next = 1'b0;
                        done_next  = 1'b0;
                        len_next   = {cnt_next, 3'b000};
                    end
                    if (ctl.shift_en && (pos == POS_LAST))
                    begin
                        rnd_next   = 7'd0;
                        state_next = S_ROUND;
                    end
                    else if (fcode != FUNC_ABSORB)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ctl.shift_en = 1'b1;
                cnt_next     = cnt_reg + 61'd1;
                if (!sent_reg)
                begin
                    ctl.shift_byte = PAD_MARKER;
                    sent_next      = 1'b1;
                end
                else if (lenph_reg || (pos == POS_LENGTH))
                begin
                    ctl.shift_byte = len_reg[3'd7 - pos[2:0]];
                    lenph_next     = 1'b1;
                    if (pos == POS_LAST)
                    begin
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    ctl.shift_byte = 8'h00;
                end
                if (pos == POS_LAST)
                begin
                    rnd_next   = 7'd0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                ctl.round_en = 1'b1;
                rnd_next     = rnd_reg + 7'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                ctl.add_en = 1'b1;
                if (fin_reg && done_reg)
                begin
                    widx_next  = 3'd0;
                    state_next = S_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (widx_reg == WORD_LAST)
                    begin
                        ctl.init_en = 1'b1;
                        cnt_next    = '0;
                        fin_next    = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        widx_next = widx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
            fin_reg   <= 1'b0;
            sent_reg  <= 1'b0;
            lenph_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
            fin_reg   <= fin_next;
            sent_reg  <= sent_next;
            lenph_reg <= lenph_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

// ----- hw/rtl/sha1_stream_hasher.sv -----
// ============================================================================
// SHA-1 stream hasher
// Hashes a byte stream with SHA-1 and returns the digest as five words.
// ============================================================================
// Each input word carries func and data_byte: absorb a byte, absorb a byte and
// finish, or finish with no byte; the unused func code is taken and ignored.
// A plain absorb byte that does not complete a 64-byte block is taken and
// leaves the block ready, so such bytes stream in back to back. A byte that
// completes a block starts the compression, during which in_ready is low: 80
// rounds through one shared round unit, then a fold of the result into the
// chaining value. On finish the padding bytes are generated internally at one
// per cycle, pausing while a block is compressed, with one or two further
// compressions, after which the five digest words are presented on the output
// channel, word_index 0 first and last_word on the fifth. The digest is held
// for as long as out_ready stays low; no input is taken until the fifth word
// is accepted, which also restores the initial chaining value and clears the
// bit count. Reset does the same and leaves the block idle and ready.
// ============================================================================
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    ctl_t ctl;

    sha1s_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    sha1s_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .digest_word (digest_word)
    );

    assign word_index = ctl.word_idx;
    assign last_word  = (ctl.word_idx == WORD_LAST);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while the digest is being presented");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (word_index <= WORD_LAST))
        else $error("digest word index out of range");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> (in_ready && !out_valid))
        else $error("block not idle after the final digest word");

    a_no_shift_and_round: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.shift_en && ctl.round_en))
        else $error("byte intake and compression round in the same cycle");

endmodule

// ----- tb/sha1_stream_hasher_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// SHA-1 stream hasher testbench
// Sends byte streams to the hasher as words carrying func and data_byte, with
// random idling on both channels, and checks every digest word against an
// independent SHA-1 computed alongside the stimulus.
// ============================================================================
module sha1_stream_hasher_test;

    import sha1s_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BOUNDARY_LEN [4] = '{55, 56, 63, 64};

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef struct packed
    {
        logic [31:0] value;
        logic [2:0]  pos;
        logic        last;
    } digest_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = 2'd0;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    logic [31:0] hash_state [5];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;

    digest_entry_t digest_expected [$];
    digest_entry_t next_digest;

    int send_idle_pct = 16;
    int recv_idle_pct = 60;
    int error_count = 0;
    int stall_cycles = 0;

    sha1_stream_hasher i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 5; i++)
        begin
            hash_state[i] = H_INIT[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            msg_block[i] = 8'd0;
        end
        msg_bits = 64'd0;
    endfunction

    function automatic void hash_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int j = 0; j < 16; j++)
        begin
            w[j] = {msg_block[4 * j], msg_block[4 * j + 1],
                    msg_block[4 * j + 2], msg_block[4 * j + 3]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16]
                                 ^ w[(r + 2) % 16] ^ w[r % 16], 1);
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
            end
            else if (r < 40 || r >= 60)
            begin
                f = b ^ c ^ d;
            end
            else
            begin
                f = (b & c) | (b & d) | (c & d);
            end
            k = K_ROUND[r / 20];
            t = rotl(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void hash_absorb(logic [7:0] v);
        msg_block[msg_bits[8:3]] = v;
        msg_bits = msg_bits + 64'd8;
        if (msg_bits[8:3] == 6'd0)
        begin
            hash_compress();
        end
    endfunction

    function automatic void hash_step(func_t f, logic [7:0] b);
        logic [63:0]   len;
        digest_entry_t entry;
        if (f == FUNC_UNUSED)
        begin
            return;
        end
        if (f != FUNC_FINISH)
        begin
            hash_absorb(b);
        end
        if (f == FUNC_ABSORB)
        begin
            return;
        end
        len = msg_bits;
        hash_absorb(8'h80);
        while (msg_bits[8:3] != 6'd56)
        begin
            hash_absorb(8'h00);
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_absorb(len[63 - 8 * i -: 8]);
        end
        for (int i = 0; i < 5; i++)
        begin
            entry.value = hash_state[i];
            entry.pos = 3'(i);
            entry.last = (i == 4);
            digest_expected.push_back(entry);
        end
        hash_restart();
    endfunction

    task automatic send_word(func_t f, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        hash_step(f, b);
    endtask

    task automatic wait_for_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_message(int len, bit end_with_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)));
            end
            if (end_with_byte && i == len - 1)
            begin
                send_word(FUNC_ABSORB_FIN, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_word(FUNC_ABSORB, 8'($urandom_range(0, 255)));
            end
        end
        if (len == 0 || !end_with_byte)
        begin
            send_word(FUNC_FINISH, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_empty_messages();
        send_word(FUNC_FINISH, 8'hFF);
        send_word(FUNC_FINISH, 8'h00);
    endtask

    task automatic test_short_messages();
        send_word(FUNC_ABSORB, 8'h61);
        send_word(FUNC_ABSORB, 8'h62);
        send_word(FUNC_ABSORB_FIN, 8'h63);
        send_word(FUNC_ABSORB_FIN, 8'h00);
        send_word(FUNC_ABSORB_FIN, 8'hFF);
        send_word(FUNC_ABSORB, 8'h5A);
        send_word(FUNC_ABSORB, 8'hA5);
        send_word(FUNC_FINISH, 8'h80);
    endtask

    task automatic test_unused_func();
        send_word(FUNC_ABSORB, 8'h5A);
        send_word(FUNC_UNUSED, 8'hA5);
        send_word(FUNC_UNUSED, 8'hFF);
        send_word(FUNC_ABSORB, 8'h00);
        send_word(FUNC_FINISH, 8'h00);
        send_word(FUNC_UNUSED, 8'h00);
        send_word(FUNC_FINISH, 8'h3C);
        wait_for_digests();
    endtask

    // Each phase opens with a message whose length sits on a block boundary,
    // so that padding just fits, spills into a second block or follows a full one.
    task automatic test_random_messages(int budget);
        int sent;
        int len;
        sent = 0;
        len = BOUNDARY_LEN[$urandom_range(0, 3)];
        while (sent < budget)
        begin
            send_message(len, 1'($urandom_range(0, 1)));
            sent += len + 1;
            if ($urandom_range(0, 3) == 0)
            begin
                wait_for_digests();
            end
            len = $urandom_range(0, 10);
        end
        wait_for_digests();
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (out_valid && out_ready)
            begin
                if (digest_expected.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h at index %0d",
                             $time, digest_word, word_index);
                    error_count++;
                end
                else
                begin
                    next_digest = digest_expected.pop_front();
                    if (digest_word !== next_digest.value)
                    begin
                        $display("%0t: digest_word expected %h, got %h",
                                 $time, next_digest.value, digest_word);
                        error_count++;
                    end
                    if (word_index !== next_digest.pos)
                    begin
                        $display("%0t: word_index expected %0d, got %0d",
                                 $time, next_digest.pos, word_index);
                        error_count++;
                    end
                    if (last_word !== next_digest.last)
                    begin
                        $display("%0t: last_word expected %b, got %b",
                                 $time, next_digest.last, last_word);
                        error_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word accepted for %0d cycles", $time, stall_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        hash_restart();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_messages();
        test_short_messages();
        test_unused_func();

        test_random_messages(60);

        send_idle_pct = 60;
        recv_idle_pct = 16;
        test_random_messages(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_messages(60);

        in_valid <= 1'b0;
        while (digest_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sha1s_pkg.sv
hw/rtl/sha1s_datapath.sv
hw/rtl/sha1s_ctrl.sv
hw/rtl/sha1_stream_hasher.sv
tb/sha1_stream_hasher_test.sv
